FILE: sv/assert_macros.svh
// Assertion macros shared by the splitter RTL.
// No dependencies; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check prop at every rising clk edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/cqfs_pkg.sv
// Shared types and constants for the CSV quoted field splitter.
// No dependencies.
`default_nettype none

package cqfs_pkg;

    // Field widths and defaults
    localparam int FIELD_BITS     = 16;
    localparam int CHAR_BITS_DEF  = 16;
    localparam logic [FIELD_BITS-1:0] QUOTE_CODE     = 16'd34;
    localparam logic [FIELD_BITS-1:0] DELIM_RESET    = 16'd44;

    // Quote tracking codes
    localparam logic [1:0] QM_UNQUOTED = 2'd0;
    localparam logic [1:0] QM_QUOTED   = 2'd1;
    localparam logic [1:0] QM_PENDING  = 2'd2;

    typedef struct packed {
        logic [1:0] quote_mode;
        logic       cell_nonempty;
    } cqfs_state_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] cell_char;
        logic                  cell_char_valid;
        logic                  cell_end;
        logic                  line_end;
    } cqfs_result_t;

endpackage

`default_nettype wire

FILE: sv/cqfs_step.sv
// Per-character parse step: result word and next quote state from one character.
// Depends on cqfs_pkg.
`default_nettype none

module cqfs_step #(
    parameter int CHAR_BITS = cqfs_pkg::CHAR_BITS_DEF
) (
    input  wire logic [cqfs_pkg::FIELD_BITS-1:0] char_code,
    input  wire logic                            has_char,
    input  wire logic                            line_last,
    input  wire logic [cqfs_pkg::FIELD_BITS-1:0] delimiter_code,
    input  wire cqfs_pkg::cqfs_state_t           state,
    output cqfs_pkg::cqfs_state_t                state_next,
    output cqfs_pkg::cqfs_result_t               result
);
    import cqfs_pkg::*;

    // Characters are compared in their low CMP_BITS bits only
    localparam int CMP_BITS = (CHAR_BITS < FIELD_BITS) ? CHAR_BITS : FIELD_BITS;
    localparam logic [FIELD_BITS-1:0] CHAR_MASK =
        FIELD_BITS'((64'd1 << CMP_BITS) - 64'd1);

    logic [FIELD_BITS-1:0] chr;
    logic [FIELD_BITS-1:0] dlm;
    logic                  plain;

    assign chr = char_code & CHAR_MASK;
    assign dlm = delimiter_code & CHAR_MASK;

    always_comb
    begin
        state_next = state;
        result     = '0;
        plain      = 1'b0;

        // Quote handling first
        if (has_char)
        begin
            case (state.quote_mode)
                QM_PENDING:
                begin
                    if (chr == QUOTE_CODE)
                    begin
                        // doubled quote gives one literal quote
                        result.cell_char        = chr;
                        result.cell_char_valid  = 1'b1;
                        state_next.cell_nonempty = 1'b1;
                        state_next.quote_mode    = QM_QUOTED;
                    end
                    else
                    begin
                        // lone quote closed quoting; treat char as unquoted
                        state_next.quote_mode = QM_UNQUOTED;
                        plain                 = 1'b1;
                    end
                end
                QM_QUOTED:
                begin
                    if (chr == QUOTE_CODE)
                    begin
                        state_next.quote_mode = QM_PENDING;
                    end
                    else
                    begin
                        result.cell_char         = chr;
                        result.cell_char_valid   = 1'b1;
                        state_next.cell_nonempty = 1'b1;
                    end
                end
                default:
                begin
                    state_next.quote_mode = QM_UNQUOTED;
                    plain                 = 1'b1;
                end
            endcase
        end

        // Unquoted character: open quotes, split, or append
        if (plain)
        begin
            if (chr == QUOTE_CODE && !state.cell_nonempty)
            begin
                state_next.quote_mode = QM_QUOTED;
            end
            else if (chr == dlm)
            begin
                result.cell_end          = 1'b1;
                state_next.cell_nonempty = 1'b0;
            end
            else
            begin
                result.cell_char         = chr;
                result.cell_char_valid   = 1'b1;
                state_next.cell_nonempty = 1'b1;
            end
        end

        // Line end closes the open cell and drops any quoting
        if (line_last)
        begin
            result.line_end          = 1'b1;
            state_next.quote_mode    = QM_UNQUOTED;
            state_next.cell_nonempty = 1'b0;
        end
    end

endmodule

`default_nettype wire

FILE: sv/csv_quoted_field_splitter_core.sv
// Channel   | Handshake                  | Payload
// s_axis    | s_axis_tvalid/tready       | tdata: char_code, tuser: has_char, tlast: line_last
// m_axis    | m_axis_tvalid/tready       | tdata: cell_char, tuser: valid/cell_end, tlast: line_end
// cfg       | cfg_wr_en (no wait)        | cfg_wr_data: delimiter_code
//
// One word in, one word out; a new word is taken every cycle while m_axis does not stall.
// Each word passes through the input register, then the parse step into the output register.
// Quote state updates as the input register hands its word to the output register.
// A stall on m_axis holds both registers; s_axis_tready drops only when both are full.
// rst_n clears valids and quote state and loads the comma delimiter.
//
// Top level of the CSV quoted field splitter.
// Depends on cqfs_pkg, cqfs_step and assert_macros.svh.
`default_nettype none

module csv_quoted_field_splitter_core #(
    parameter int CHAR_BITS = cqfs_pkg::CHAR_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            cfg_wr_en,
    input  wire logic [cqfs_pkg::FIELD_BITS-1:0] cfg_wr_data,
    // input stream
    input  wire logic                            s_axis_tvalid,
    output      logic                            s_axis_tready,
    input  wire logic [cqfs_pkg::FIELD_BITS-1:0] s_axis_tdata,   // [15:0] char_code
    input  wire logic [0:0]                      s_axis_tuser,   // [0] has_char
    input  wire logic                            s_axis_tlast,   // line_last
    // output stream
    output      logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output      logic [cqfs_pkg::FIELD_BITS-1:0] m_axis_tdata,   // [15:0] cell_char
    output      logic [1:0]                      m_axis_tuser,   // [0] cell_char_valid, [1] cell_end
    output      logic                            m_axis_tlast    // line_end
);
    import cqfs_pkg::*;

    logic [FIELD_BITS-1:0] delim_reg;

    logic                  in_valid_reg;
    logic [FIELD_BITS-1:0] in_char_reg;
    logic                  in_has_reg;
    logic                  in_last_reg;

    cqfs_state_t           state_reg;
    cqfs_state_t           state_next;
    cqfs_result_t          res_next;
    cqfs_result_t          res_reg;
    logic                  out_valid_reg;

    logic                  out_free;
    logic                  step_fire;
    logic                  in_fire;

    // Handshake: advance when the next register is free
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step_fire     = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Delimiter register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= DELIM_RESET;
        end
        else if (cfg_wr_en)
        begin
            delim_reg <= cfg_wr_data;
        end
    end

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step_fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_char_reg <= s_axis_tdata;
            in_has_reg  <= s_axis_tuser[0];
            in_last_reg <= s_axis_tlast;
        end
    end

    // Parse step
    cqfs_step #(
        .CHAR_BITS (CHAR_BITS)
    ) u_step (
        .char_code      (in_char_reg),
        .has_char       (in_has_reg),
        .line_last      (in_last_reg),
        .delimiter_code (delim_reg),
        .state          (state_reg),
        .state_next     (state_next),
        .result         (res_next)
    );

    // Quote state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step_fire)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = res_reg.cell_char;
    assign m_axis_tuser  = {res_reg.cell_end, res_reg.cell_char_valid};
    assign m_axis_tlast  = res_reg.line_end;

`include "assert_macros.svh"

    `ASSERT_CLK(a_step_fills_out, step_fire |=> out_valid_reg, "step word lost")
    `ASSERT_CLK(a_line_end_clears, (step_fire && in_last_reg) |=> (state_reg == '0), "state kept past line end")
    `ASSERT_CLK(a_char_or_split, m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]), "char and cell end together")
    `ASSERT_CLK(a_empty_char_zero, (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0), "stray char bits")

endmodule

`default_nettype wire
